@@ hw/rtl/pgb_pkg.sv @@
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types, widths and helpers for the particle-to-grid cell binning block.
// ----------------------------------------------------------------------------
package pgb_pkg;

  // Block configuration
  localparam int NUM_DIMS          = 3;
  localparam int MAX_CELLS_PER_DIM = 256;
  localparam int MAX_SPAN          = 3;

  // Fixed field widths
  localparam int DIMS       = 3;             // physical axes x, y, z
  localparam int COORD_W    = 24;            // unsigned Q16.8
  localparam int SUM_W      = COORD_W + 1;   // centre + radius
  localparam int TAG_W      = 16;
  localparam int IDX_W      = 24;
  localparam int CELLS_W    = 9;
  localparam int WIDTH_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Derived widths
  localparam int QUOT_W    = $clog2(MAX_CELLS_PER_DIM) + 1;     // saturating quotient
  localparam int NC_W      = $clog2(MAX_CELLS_PER_DIM + 1);
  localparam int K_W       = (NC_W > QUOT_W) ? NC_W : QUOT_W;  // cell number width
  localparam int SPAN_W    = $clog2(MAX_SPAN + 1);
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // Reset values of the configuration registers
  localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(1);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X,
    REG_CELLS_Y,
    REG_CELLS_Z,
    REG_WIDTH_X,
    REG_WIDTH_Y,
    REG_WIDTH_Z
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_BOUNDS,
    S_CHECK,
    S_INDEX1,
    S_INDEX2,
    S_EMIT,
    S_OVF
  } state_t;

  typedef struct packed {
    logic load;      // latch particle, start dividers
    logic div_step;  // one quotient bit
    logic bounds;    // latch kmin/kmax
    logic check;     // latch spans, first products
    logic index1;    // row product
    logic index2;    // start index
    logic emit;      // write cell result, advance walk
    logic emit_ovf;  // write overflow result
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic ovf;
    logic last;
  } dp_status_t;

  // Cell count with 0 taken as 1 and clamped to the supported maximum
  function automatic logic [K_W-1:0] eff_cells(input logic [CELLS_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v == 0) v = 1;
    if (v > MAX_CELLS_PER_DIM) v = MAX_CELLS_PER_DIM;
    return K_W'(v);
  endfunction

  // Index product, modulo 2^IDX_W
  function automatic logic [IDX_W-1:0] mul_idx(input logic [IDX_W-1:0] a,
                                              input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

@@ hw/rtl/pgb_div.sv @@
// ----------------------------------------------------------------------------
// pgb_div
// Bit-serial restoring divider with a saturating quotient, one bit per step.
// ----------------------------------------------------------------------------
module pgb_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [pgb_pkg::SUM_W-1:0]   dividend,
  input  logic [pgb_pkg::WIDTH_W-1:0] divisor,
  output logic [pgb_pkg::QUOT_W-1:0]  quot
);

  localparam int QW = pgb_pkg::QUOT_W;
  localparam int SW = pgb_pkg::SUM_W;
  localparam int WW = pgb_pkg::WIDTH_W;

  logic [WW-1:0]    rem;
  logic [WW-1:0]    dvs;
  logic [QW-1:0]    dvd_lo;
  logic [QW-1:0]    quot_q;
  logic             sat;
  logic [SW-QW-1:0] dvd_hi;
  logic [WW:0]      trial;
  logic [WW:0]      diff;
  logic             ge;

  assign dvd_hi = dividend[SW-1:QW];
  assign trial  = {rem, dvd_lo[QW-1]};
  assign diff   = trial - {1'b0, dvs};
  assign ge     = (trial >= {1'b0, dvs});

  // quotient >= 2^QW is reported as all ones
  always_ff @(posedge clk) begin
    if (load) begin
      dvs    <= divisor;
      sat    <= (WW'(dvd_hi) >= divisor);
      rem    <= WW'(dvd_hi);
      dvd_lo <= dividend[QW-1:0];
      quot_q <= '0;
    end else if (step) begin
      rem    <= ge ? diff[WW-1:0] : trial[WW-1:0];
      dvd_lo <= {dvd_lo[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign quot = sat ? '1 : quot_q;

endmodule

@@ hw/rtl/pgb_datapath.sv @@
// ----------------------------------------------------------------------------
// pgb_datapath
// Config registers, per-axis range dividers, cell walk and result register.
// ----------------------------------------------------------------------------
module pgb_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_x,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_y,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_z,
  input  logic [pgb_pkg::COORD_W-1:0]    radius,
  input  logic [pgb_pkg::TAG_W-1:0]      particle_tag,
  input  logic                           final_particle,
  input  pgb_pkg::dp_cmd_t               cmd,
  output pgb_pkg::dp_status_t            status,
  output logic [pgb_pkg::TAG_W-1:0]      tag_out,
  output logic [pgb_pkg::IDX_W-1:0]      cell_index,
  output logic                           last_cell,
  output logic                           batch_end,
  output logic                           overflow
);

  localparam int D   = pgb_pkg::DIMS;
  localparam int CW  = pgb_pkg::COORD_W;
  localparam int SUW = pgb_pkg::SUM_W;
  localparam int WW  = pgb_pkg::WIDTH_W;
  localparam int QW  = pgb_pkg::QUOT_W;
  localparam int KW  = pgb_pkg::K_W;
  localparam int SPW = pgb_pkg::SPAN_W;
  localparam int IW  = pgb_pkg::IDX_W;
  localparam int NW  = pgb_pkg::CELLS_W;

  logic [NW-1:0]  cells_q [D];
  logic [WW-1:0]  width_q [D];
  logic [CW-1:0]  pos_a   [D];
  logic [KW-1:0]  nc_eff  [D];
  logic [KW-1:0]  ncm1    [D];
  logic [KW-1:0]  kmin_c  [D];
  logic [KW-1:0]  kmax_c  [D];
  logic [KW-1:0]  kmin_q  [D];
  logic [KW-1:0]  kmax_q  [D];
  logic [KW-1:0]  kdiff   [D];
  logic [D-1:0]   emp;
  logic [D-1:0]   ov;
  logic [SPW-1:0] spm1    [D];
  logic [SPW-1:0] cnt     [D];

  logic [pgb_pkg::TAG_W-1:0] tag_q;
  logic                      fin_q;
  logic [IW-1:0]             m1;
  logic [IW-1:0]             nxy;
  logic [IW-1:0]             prod;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             ybase;
  logic [IW-1:0]             zbase;
  logic [IW-1:0]             stride_y;
  logic                      walk_last;

  assign pos_a[0] = pos_x;
  assign pos_a[1] = pos_y;
  assign pos_a[2] = pos_z;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < D; d++) begin
        cells_q[d] <= pgb_pkg::CELLS_RESET;
        width_q[d] <= pgb_pkg::WIDTH_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgb_pkg::REG_CELLS_X: cells_q[0] <= cfg_data[NW-1:0];
        pgb_pkg::REG_CELLS_Y: cells_q[1] <= cfg_data[NW-1:0];
        pgb_pkg::REG_CELLS_Z: cells_q[2] <= cfg_data[NW-1:0];
        pgb_pkg::REG_WIDTH_X: width_q[0] <= cfg_data[WW-1:0];
        pgb_pkg::REG_WIDTH_Y: width_q[1] <= cfg_data[WW-1:0];
        pgb_pkg::REG_WIDTH_Z: width_q[2] <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < D; d++) begin
      nc_eff[d] = pgb_pkg::eff_cells(cells_q[d]);
      ncm1[d]   = nc_eff[d] - KW'(1);
    end
  end

  // Per-axis cell range: kmin = (lo-1)/w, kmax = min(hi/w, n-1)
  for (genvar d = 0; d < D; d++) begin : g_dim
    if (d < pgb_pkg::NUM_DIMS) begin : g_used
      logic [WW-1:0]  wdiv;
      logic [SUW-1:0] hi_sum;
      logic [CW-1:0]  lo_m1;
      logic           lo_neg;
      logic [QW-1:0]  qlo;
      logic [QW-1:0]  qhi;
      logic [KW-1:0]  qhi_k;

      assign wdiv   = (width_q[d] == '0) ? WW'(1) : width_q[d];
      assign hi_sum = SUW'(pos_a[d]) + SUW'(radius);
      assign lo_m1  = pos_a[d] - radius - CW'(1);

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          lo_neg <= (pos_a[d] <= radius);
        end
      end

      pgb_div u_div_lo (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (SUW'(lo_m1)),
        .divisor  (wdiv),
        .quot     (qlo)
      );

      pgb_div u_div_hi (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (hi_sum),
        .divisor  (wdiv),
        .quot     (qhi)
      );

      assign qhi_k     = KW'(qhi);
      assign kmin_c[d] = lo_neg ? '0 : KW'(qlo);
      assign kmax_c[d] = (qhi_k > ncm1[d]) ? ncm1[d] : qhi_k;
    end else begin : g_unused
      assign kmin_c[d] = '0;
      assign kmax_c[d] = '0;
    end
  end

  always_comb begin
    for (int d = 0; d < D; d++) begin
      kdiff[d] = kmax_q[d] - kmin_q[d];
      emp[d]   = (kmin_q[d] > kmax_q[d]);
      ov[d]    = (kdiff[d] >= KW'(pgb_pkg::MAX_SPAN));
    end
  end

  assign walk_last = (cnt[0] == '0) && (cnt[1] == '0) && (cnt[2] == '0);
  assign stride_y  = IW'(nc_eff[0]);

  assign status.empty = |emp;
  assign status.ovf   = |ov;
  assign status.last  = walk_last;

  // Particle latch, bounds, index set-up and cell walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q <= particle_tag;
      fin_q <= final_particle;
    end
    if (cmd.bounds) begin
      for (int d = 0; d < D; d++) begin
        kmin_q[d] <= kmin_c[d];
        kmax_q[d] <= kmax_c[d];
      end
    end
    if (cmd.check) begin
      for (int d = 0; d < D; d++) begin
        spm1[d] <= kdiff[d][SPW-1:0];
        cnt[d]  <= kdiff[d][SPW-1:0];
      end
      m1  <= pgb_pkg::mul_idx(IW'(nc_eff[1]), IW'(kmax_q[2]));
      nxy <= pgb_pkg::mul_idx(IW'(nc_eff[0]), IW'(nc_eff[1]));
    end
    if (cmd.index1) begin
      prod <= pgb_pkg::mul_idx(IW'(nc_eff[0]), m1 + IW'(kmax_q[1]));
    end
    if (cmd.index2) begin
      idx   <= prod + IW'(kmax_q[0]);
      ybase <= prod + IW'(kmax_q[0]);
      zbase <= prod + IW'(kmax_q[0]);
    end
    if (cmd.emit) begin
      priority if (cnt[0] != '0) begin
        cnt[0] <= cnt[0] - SPW'(1);
        idx    <= idx - IW'(1);
      end else if (cnt[1] != '0) begin
        cnt[0] <= spm1[0];
        cnt[1] <= cnt[1] - SPW'(1);
        ybase  <= ybase - stride_y;
        idx    <= ybase - stride_y;
      end else if (cnt[2] != '0) begin
        cnt[0] <= spm1[0];
        cnt[1] <= spm1[1];
        cnt[2] <= cnt[2] - SPW'(1);
        zbase  <= zbase - nxy;
        ybase  <= zbase - nxy;
        idx    <= zbase - nxy;
      end else begin
        // last cell of the walk, counters stay at zero
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tag_out    <= tag_q;
      cell_index <= idx;
      last_cell  <= walk_last;
      batch_end  <= walk_last & fin_q;
      overflow   <= 1'b0;
    end else if (cmd.emit_ovf) begin
      tag_out    <= tag_q;
      cell_index <= '0;
      last_cell  <= 1'b1;
      batch_end  <= fin_q;
      overflow   <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/pgb_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgb_ctrl
// Sequencer: divide, bound, check, set-up; a result per cycle unless stalled.
// ----------------------------------------------------------------------------
module pgb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pgb_pkg::dp_cmd_t    cmd,
  input  pgb_pkg::dp_status_t status
);

  localparam int DCW = pgb_pkg::DIV_CNT_W;

  pgb_pkg::state_t state;
  pgb_pkg::state_t state_next;
  logic [DCW-1:0]  div_cnt;
  logic            emit_ok;

  // result register free, or being emptied this cycle
  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pgb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit || cmd.emit_ovf) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_cnt <= DCW'(pgb_pkg::QUOT_W - 1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pgb_pkg::S_IDLE:   if (in_valid) state_next = pgb_pkg::S_DIVIDE;
      pgb_pkg::S_DIVIDE: if (div_cnt == '0) state_next = pgb_pkg::S_BOUNDS;
      pgb_pkg::S_BOUNDS: state_next = pgb_pkg::S_CHECK;
      pgb_pkg::S_CHECK: begin
        priority if (status.empty) state_next = pgb_pkg::S_IDLE;
        else if (status.ovf)       state_next = pgb_pkg::S_OVF;
        else                       state_next = pgb_pkg::S_INDEX1;
      end
      pgb_pkg::S_INDEX1: state_next = pgb_pkg::S_INDEX2;
      pgb_pkg::S_INDEX2: state_next = pgb_pkg::S_EMIT;
      pgb_pkg::S_EMIT:   if (emit_ok && status.last) state_next = pgb_pkg::S_IDLE;
      pgb_pkg::S_OVF:    if (emit_ok) state_next = pgb_pkg::S_IDLE;
      default:           state_next = pgb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (state == pgb_pkg::S_IDLE);
    cmd.load     = (state == pgb_pkg::S_IDLE) && in_valid;
    cmd.div_step = (state == pgb_pkg::S_DIVIDE);
    cmd.bounds   = (state == pgb_pkg::S_BOUNDS);
    cmd.check    = (state == pgb_pkg::S_CHECK);
    cmd.index1   = (state == pgb_pkg::S_INDEX1);
    cmd.index2   = (state == pgb_pkg::S_INDEX2);
    cmd.emit     = (state == pgb_pkg::S_EMIT) && emit_ok;
    cmd.emit_ovf = (state == pgb_pkg::S_OVF) && emit_ok;
  end

  a_accept_divides: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == pgb_pkg::S_DIVIDE))
    else $error("accepted transaction did not start division");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_ovf) |=> out_valid)
    else $error("result written but out_valid low");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |=> (state == pgb_pkg::S_IDLE))
    else $error("cell walk continued past last cell");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command active");

endmodule

@@ hw/rtl/particle_to_grid_cell_binning.sv @@
// ----------------------------------------------------------------------------
// particle_to_grid_cell_binning
// Uniform-grid broad-phase binning: emits the cells that a particle touches.
// ----------------------------------------------------------------------------
// One particle is taken at a time. After the input transaction, two
// bit-serial dividers per axis with a 9-bit quotient find the first and
// last overlapped cell; the bound and check steps then tell whether the
// item is empty (no result) or overflowing (one overflow result). Otherwise
// two set-up steps find the starting cell index, then one result
// transaction leaves per cycle while the consumer keeps up, 27 at most.
// The next particle is accepted in the cycle after the last result is
// written; a finished result may still sit in the output register then.
// Configuration writes must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module particle_to_grid_cell_binning (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [pgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgb_pkg::CFG_DATA_W-1:0] cfg_data,
  // particle input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_x,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_y,
  input  logic [pgb_pkg::COORD_W-1:0]    pos_z,
  input  logic [pgb_pkg::COORD_W-1:0]    radius,
  input  logic [pgb_pkg::TAG_W-1:0]      particle_tag,
  input  logic                           final_particle,
  // cell result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pgb_pkg::TAG_W-1:0]      tag_out,
  output logic [pgb_pkg::IDX_W-1:0]      cell_index,
  output logic                           last_cell,
  output logic                           batch_end,
  output logic                           overflow
);

  // Controller issues at most one command per cycle; datapath answers with
  // empty / overflow (valid in the check cycle) and end-of-walk.
  pgb_pkg::dp_cmd_t    cmd;
  pgb_pkg::dp_status_t status;

  pgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: config registers, dividers, cell walk (x fastest, each axis
  // descending) and the output register that decouples the two channels.
  pgb_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .radius         (radius),
    .particle_tag   (particle_tag),
    .final_particle (final_particle),
    .cmd            (cmd),
    .status         (status),
    .tag_out        (tag_out),
    .cell_index     (cell_index),
    .last_cell      (last_cell),
    .batch_end      (batch_end),
    .overflow       (overflow)
  );

endmodule

@@ test/particle_to_grid_cell_binning_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_to_grid_cell_binning_test
// Self-checking bench: random particles against an in-bench cell-range binner.
// ----------------------------------------------------------------------------
module particle_to_grid_cell_binning_test;

  localparam int DIMS              = pgb_pkg::DIMS;
  localparam int NUM_DIMS          = pgb_pkg::NUM_DIMS;
  localparam int MAX_CELLS_PER_DIM = pgb_pkg::MAX_CELLS_PER_DIM;
  localparam int MAX_SPAN          = pgb_pkg::MAX_SPAN;
  localparam int COORD_W           = pgb_pkg::COORD_W;
  localparam int TAG_W             = pgb_pkg::TAG_W;
  localparam int IDX_W             = pgb_pkg::IDX_W;
  localparam int CELLS_W           = pgb_pkg::CELLS_W;
  localparam int WIDTH_W           = pgb_pkg::WIDTH_W;
  localparam int CFG_IDX_W         = pgb_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W        = pgb_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [DIMS-1:0][COORD_W-1:0] pos;
    logic [COORD_W-1:0]           radius;
    logic [TAG_W-1:0]             tag;
    logic                         end_of_batch;
  } particle_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             batch_end;
    logic             ovf;
  } cell_result_t;

  // Stimulus kinds for the random part
  localparam int KIND_IN_GRID  = 0;  // centre inside the grid, radius up to half a cell
  localparam int KIND_WIDE     = 1;  // centre inside the grid, radius up to two cells
  localparam int KIND_NOISE    = 2;  // any value of any field

  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES  = 50;   // longer than the largest walk of one particle
  localparam int EMPTY_CYCLES  = 20;   // longer than a particle with no result takes
  localparam int PATIENCE      = 50000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_W-1:0]    pos_x = '0;
  logic [COORD_W-1:0]    pos_y = '0;
  logic [COORD_W-1:0]    pos_z = '0;
  logic [COORD_W-1:0]    radius = '0;
  logic [TAG_W-1:0]      particle_tag = '0;
  logic                  final_particle = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TAG_W-1:0]      tag_out;
  logic [IDX_W-1:0]      cell_index;
  logic                  last_cell;
  logic                  batch_end;
  logic                  overflow;

  particle_to_grid_cell_binning dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .radius         (radius),
    .particle_tag   (particle_tag),
    .final_particle (final_particle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tag_out        (tag_out),
    .cell_index     (cell_index),
    .last_cell      (last_cell),
    .batch_end      (batch_end),
    .overflow       (overflow)
  );

  // Shadow copy of the grid registers, kept in step with every write
  logic [CELLS_W-1:0] cells_cfg [DIMS];
  logic [WIDTH_W-1:0] width_cfg [DIMS];

  particle_t    particles_to_send [$];
  cell_result_t cells_due [$];

  int particles_queued   = 0;
  int particles_accepted = 0;
  int particles_empty    = 0;
  int cells_checked      = 0;
  int overflow_seen      = 0;
  int batch_ends_seen    = 0;
  int grid_settings      = 1;  // reset grid counts as the first
  int mismatch_count     = 0;
  bit random_started     = 1'b0;
  logic rx_hold          = 1'b0;

  // -------------------------------------------------------------------------
  // Grid helpers: effective cell count and width of one axis
  // -------------------------------------------------------------------------
  function automatic longint grid_cells(int d);
    longint v;
    v = longint'(cells_cfg[d]);
    if (v == 0) v = 1;
    if (v > MAX_CELLS_PER_DIM) v = MAX_CELLS_PER_DIM;
    return v;
  endfunction

  function automatic longint grid_width(int d);
    longint v;
    v = longint'(width_cfg[d]);
    if (v == 0) v = 1;
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Predictor: cell ranges per axis, then the walk over their product.
  // x fastest, each axis walked from its top cell down.
  // -------------------------------------------------------------------------
  function automatic void bin_particle(particle_t p);
    longint lo, hi, w;
    longint first [DIMS];
    longint top [DIMS];
    longint ncell [DIMS];
    longint x, y, z;
    bit empty, wide;
    cell_result_t r;
    empty = 1'b0;
    wide  = 1'b0;
    for (int d = 0; d < DIMS; d++) begin
      ncell[d] = grid_cells(d);
      if (d >= NUM_DIMS) begin
        first[d] = 0;
        top[d]   = 0;
      end else begin
        w  = grid_width(d);
        lo = longint'(p.pos[d]) - longint'(p.radius);
        hi = longint'(p.pos[d]) + longint'(p.radius);
        // closed spans: a bound sitting on a face touches both cells
        first[d] = (lo <= 0) ? 0 : (lo - 1) / w;
        top[d]   = hi / w;
        if (top[d] > ncell[d] - 1) top[d] = ncell[d] - 1;
      end
      if (first[d] > top[d]) empty = 1'b1;
      else if (top[d] - first[d] + 1 > MAX_SPAN) wide = 1'b1;
    end
    // an axis with no cell wins over an oversized axis
    if (empty) begin
      particles_empty++;
      return;
    end
    if (wide) begin
      r = '{tag: p.tag, idx: '0, last: 1'b1, batch_end: p.end_of_batch, ovf: 1'b1};
      cells_due.push_back(r);
      return;
    end
    for (z = top[2]; z >= first[2]; z--) begin
      for (y = top[1]; y >= first[1]; y--) begin
        for (x = top[0]; x >= first[0]; x--) begin
          r.tag       = p.tag;
          r.idx       = IDX_W'(x + ncell[0] * (y + ncell[1] * z));
          r.last      = (x == first[0]) && (y == first[1]) && (z == first[2]);
          r.batch_end = r.last && p.end_of_batch;
          r.ovf       = 1'b0;
          cells_due.push_back(r);
        end
      end
    end
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // -------------------------------------------------------------------------
  // Random particle; in-grid kinds pick a cell per axis and sit somewhere on it
  // -------------------------------------------------------------------------
  function automatic particle_t make_particle(int kind);
    particle_t p;
    longint w, c, r;
    int rd;
    p.tag          = TAG_W'($urandom_range(0, 16'hFFFF));
    p.end_of_batch = ($urandom_range(0, 7) == 0);
    if (kind == KIND_NOISE) begin
      for (int d = 0; d < DIMS; d++) p.pos[d] = COORD_W'($urandom);
      p.radius = $urandom_range(0, 1) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 1023));
      return p;
    end
    for (int d = 0; d < DIMS; d++) begin
      w = grid_width(d);
      c = w * longint'($urandom_range(0, int'(grid_cells(d)) - 1)) + longint'($urandom_range(0, w));
      if (c > 24'hFFFFFF) c = longint'($urandom_range(0, 24'hFFFFFF));
      p.pos[d] = COORD_W'(c);
    end
    // radius scaled to the width of one random axis
    rd = $urandom_range(0, DIMS - 1);
    w  = grid_width(rd);
    if (kind == KIND_IN_GRID) r = longint'($urandom_range(0, w / 2));
    else r = longint'($urandom_range(0, 2 * w));
    if (r > 24'hFFFFFF) r = 24'hFFFFFF;
    p.radius = COORD_W'(r);
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus-side tasks
  // -------------------------------------------------------------------------
  task automatic queue_particle(particle_t p);
    particles_to_send.push_back(p);
    particles_queued++;
  endtask

  task automatic send(int px, int py, int pz, int r, int tag, bit fin);
    particle_t p;
    p.pos[0]       = COORD_W'(px);
    p.pos[1]       = COORD_W'(py);
    p.pos[2]       = COORD_W'(pz);
    p.radius       = COORD_W'(r);
    p.tag          = TAG_W'(tag);
    p.end_of_batch = fin;
    queue_particle(p);
  endtask

  task automatic write_reg(pgb_pkg::cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    if (which < pgb_pkg::REG_WIDTH_X) cells_cfg[int'(which)] = value[CELLS_W-1:0];
    else width_cfg[int'(which) - int'(pgb_pkg::REG_WIDTH_X)] = value[WIDTH_W-1:0];
  endtask

  // Only called with the block idle
  task automatic set_grid(int cx, int cy, int cz, int wx, int wy, int wz);
    write_reg(pgb_pkg::REG_CELLS_X, CFG_DATA_W'(cx));
    write_reg(pgb_pkg::REG_CELLS_Y, CFG_DATA_W'(cy));
    write_reg(pgb_pkg::REG_CELLS_Z, CFG_DATA_W'(cz));
    write_reg(pgb_pkg::REG_WIDTH_X, CFG_DATA_W'(wx));
    write_reg(pgb_pkg::REG_WIDTH_Y, CFG_DATA_W'(wy));
    write_reg(pgb_pkg::REG_WIDTH_Z, CFG_DATA_W'(wz));
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_settings++;
  endtask

  // Sender pause: every particle taken, every result back, and then time for
  // a trailing particle that yields no result to finish its divide.
  task automatic wait_idle();
    int patience;
    patience = PATIENCE;
    while ((particles_accepted != particles_queued || cells_due.size() != 0) && patience > 0) begin
      @(posedge clk);
      patience--;
    end
    repeat (EMPTY_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) queue_particle(make_particle(KIND_IN_GRID));
      else if (roll < 85) queue_particle(make_particle(KIND_WIDE));
      else queue_particle(make_particle(KIND_NOISE));
    end
    wait_idle();
  endtask

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Driver: sends queued particles in bursts with random gaps. Valid and the
  // payload stay put until the transaction completes; the prediction is made
  // at the edge the particle is taken.
  // -------------------------------------------------------------------------
  particle_t on_offer;
  bit        in_fire;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        bin_particle(on_offer);
        particles_accepted++;
      end
      if (in_valid && !in_fire) begin
        // keep offering the same particle
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (particles_to_send.size() > 0) begin
        on_offer = particles_to_send.pop_front();
        in_valid       <= 1'b1;
        pos_x          <= on_offer.pos[0];
        pos_y          <= on_offer.pos[1];
        pos_z          <= on_offer.pos[2];
        radius         <= on_offer.radius;
        particle_tag   <= on_offer.tag;
        final_particle <= on_offer.end_of_batch;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // a third of the bursts run straight into the next one
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest expectation.
  // Ready follows its own pattern: stretches of always-ready, coin-flip and
  // mostly-stalled, and is forced low during the long hold-off.
  // -------------------------------------------------------------------------
  cell_result_t got, want;
  int           rx_mode = 0;
  int           rx_left = 0;
  bit           rx_want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_mode   = 0;
      rx_left   = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{tag: tag_out, idx: cell_index, last: last_cell,
                batch_end: batch_end, ovf: overflow};
        if (overflow === 1'b1) overflow_seen++;
        if (batch_end === 1'b1) batch_ends_seen++;
        if (cells_due.size() == 0) begin
          flag_error($sformatf("result with nothing pending: tag %h idx %0d last %b end %b ovf %b",
                               got.tag, got.idx, got.last, got.batch_end, got.ovf));
        end else begin
          want = cells_due.pop_front();
          cells_checked++;
          if (got.tag !== want.tag || got.idx !== want.idx || got.last !== want.last ||
              got.batch_end !== want.batch_end || got.ovf !== want.ovf)
            flag_error($sformatf({"expected tag %h idx %0d last %b end %b ovf %b, ",
                                  "got tag %h idx %0d last %b end %b ovf %b"},
                                 want.tag, want.idx, want.last, want.batch_end, want.ovf,
                                 got.tag, got.idx, got.last, got.batch_end, got.ovf));
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(4, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: rx_want = 1'b1;
        1: rx_want = $urandom_range(0, 1);
        default: rx_want = ($urandom_range(0, 3) == 0);
      endcase
      out_ready <= rx_want && !rx_hold;
    end
  end

  // -------------------------------------------------------------------------
  // Long receiver hold-off early in the random part: the sender keeps
  // offering, so the block backs up and drops in_ready.
  // -------------------------------------------------------------------------
  initial begin
    wait (random_started);
    repeat (30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // Run limit
  // -------------------------------------------------------------------------
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    for (int d = 0; d < DIMS; d++) begin
      cells_cfg[d] = pgb_pkg::CELLS_RESET;
      width_cfg[d] = pgb_pkg::WIDTH_RESET;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset grid: one cell of width 2.0 per axis
    send(0, 0, 0, 0, 16'h0000, 1'b0);                  // origin, single cell
    send(512, 512, 512, 0, 16'h0001, 1'b0);            // on the top face
    send(513, 0, 0, 0, 16'h0002, 1'b1);                // past the grid: no result, no batch end
    send(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1);  // all fields at max
    wait_idle();

    set_grid(8, 8, 8, 256, 256, 256);
    send(256, 256, 256, 0, 16'h1234, 1'b0);            // on interior faces: 2x2x2
    send(300, 300, 300, 300, 16'h5678, 1'b0);          // 3x3x3, the largest walk
    send(512, 512, 512, 400, 16'h9ABC, 1'b1);          // span 4: overflow with batch end
    send(24'hFFFFFF, 512, 512, 400, 16'hDEF0, 1'b1);   // empty axis beats overflow
    send(10, 20, 30, 100, 16'h0F0F, 1'b0);             // interval dips below zero
    send(2048, 2048, 2048, 0, 16'hF0F0, 1'b0);         // top corner cell
    send(700, 900, 1100, 0, 16'h00FF, 1'b1);           // single cell ends the batch
    send(2049, 0, 0, 0, 16'hFF00, 1'b0);               // just past the top face
    wait_idle();

    // Count 511 clamps to the maximum, count 0 and width 0 act as 1;
    // junk above the count bits must be dropped.
    set_grid(24'hABC1FF, 0, 256, 0, 24'hFFFFFF, 1);
    send(255, 24'hFFFFFF, 255, 0, 16'h1111, 1'b0);
    send(0, 0, 0, 1, 16'h2222, 1'b0);
    send(3, 3, 3, 1, 16'h3333, 1'b1);
    wait_idle();

    set_grid(256, 256, 256, 1, 1, 1);
    send(256, 256, 256, 0, 16'hFFFF, 1'b1);            // largest linear index
    send(255, 255, 255, 1, 16'h4444, 1'b0);            // 27 results near the top
    wait_idle();

    // Random part, a new grid per phase
    random_started = 1'b1;
    set_grid(4, 3, 2, 256, 768, 5000);
    run_random_phase(70);
    set_grid(24'h7E0100, 256, 256, 1, 2, 1);
    run_random_phase(75);
    set_grid(511, 0, 7, 0, 24'hFFFFFF, 3000);
    run_random_phase(75);
    set_grid(3, 2, 1, 24'hFFFFFF, 24'h800000, 512);
    run_random_phase(75);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cells_due.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", cells_due.size()));

    $display("Covered %0d particles over %0d grid settings, %0d results checked",
             particles_accepted, grid_settings, cells_checked);
    $display("  %0d overflow results, %0d batch ends, %0d particles touching no cell",
             overflow_seen, batch_ends_seen, particles_empty);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pgb_pkg.sv
hw/rtl/pgb_div.sv
hw/rtl/pgb_datapath.sv
hw/rtl/pgb_ctrl.sv
hw/rtl/particle_to_grid_cell_binning.sv
test/particle_to_grid_cell_binning_test.sv
